@@ rtl/jtps_pkg.sv @@
// Shared types, constants and helper functions for the job table scheduler.
// Used by the rank comparator and the top level.
package jtps_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int NUM_QUEUES  = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SCAN_W      = IDX_W + 1;
    localparam int ACT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 64;

    localparam logic [CFG_IDX_W-1:0] REG_QPRIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QLIM  = 1'b1;

    localparam logic [2:0] ST_QUEUED   = 3'd0;
    localparam logic [2:0] ST_ACTIVE   = 3'd1;
    localparam logic [2:0] ST_PAUSED   = 3'd2;
    localparam logic [2:0] ST_ERROR    = 3'd3;
    localparam logic [2:0] ST_CANCELED = 3'd4;
    localparam logic [2:0] ST_OTHER    = 3'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_LOAD     = 4'd1,
        ACT_SEED     = 4'd2,
        ACT_REMOVE   = 4'd3,
        ACT_FORGET   = 4'd4,
        ACT_CANCEL   = 4'd5,
        ACT_PAUSE    = 4'd6,
        ACT_RESUME   = 4'd7,
        ACT_SETSTAT  = 4'd8,
        ACT_SETRETRY = 4'd9,
        ACT_PICK     = 4'd10,
        ACT_GETSTAT  = 4'd11,
        ACT_COUNT    = 4'd12,
        ACT_REASSIGN = 4'd13
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0]        id;
        logic [2:0]         status;
        logic [3:0]         queue;
        logic signed [7:0]  prio;
        logic [31:0]        created;
        logic [31:0]        retry;
        logic               cpend;
        logic               ppend;
    } t_entry;

    typedef struct packed {
        logic [31:0]      result_id;
        logic             found;
        logic             done_flag;
        logic [2:0]       status_out;
        logic [CNT_W-1:0] match_count;
    } t_result;

    function automatic logic [2:0] norm_status(input logic [2:0] s);
        return (s > ST_OTHER) ? ST_OTHER : s;
    endfunction

    function automatic logic [3:0] norm_queue(input logic [3:0] q);
        return (q == 4'd0) ? 4'd1 : q;
    endfunction

    function automatic logic signed [7:0] queue_prio(input logic [CFG_W-1:0] tbl,
                                                     input logic [3:0] q);
        logic signed [7:0] p;
        p = '0;
        for (int k = 0; k < NUM_QUEUES; k++) begin
            if (q == 4'(k + 1)) begin
                p = tbl[8*k +: 8];
            end
        end
        return p;
    endfunction

endpackage

@@ rtl/jtps_if.sv @@
// Command and result channel interfaces of the job table scheduler.
// Plain valid/ready channels; no package dependency.
interface jtps_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         action;
    logic [31:0]        entry_id;
    logic [31:0]        now;
    logic [2:0]         status_value;
    logic [3:0]         queue_number;
    logic signed [7:0]  entry_priority;
    logic [31:0]        created_time;
    logic [31:0]        retry_time;

    modport source (output valid, action, entry_id, now, status_value, queue_number,
                    entry_priority, created_time, retry_time, input ready);
    modport sink   (input valid, action, entry_id, now, status_value, queue_number,
                    entry_priority, created_time, retry_time, output ready);
endinterface

interface jtps_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_id;
    logic        found;
    logic        done_flag;
    logic [2:0]  status_out;
    logic [4:0]  match_count;

    modport source (output valid, result_id, found, done_flag, status_out, match_count,
                    input ready);
    modport sink   (input valid, result_id, found, done_flag, status_out, match_count,
                    output ready);
endinterface

@@ rtl/jtps_rank.sv @@
// Pick ordering comparator: is the candidate job strictly better than the best so far.
// Depends on jtps_pkg for the entry layout.
module jtps_rank (
    input  logic signed [7:0] i_cand_qp,
    input  jtps_pkg::t_entry  i_cand,
    input  logic signed [7:0] i_best_qp,
    input  jtps_pkg::t_entry  i_best,
    input  logic              i_best_vld,
    output logic              o_better
);
    import jtps_pkg::*;

    logic created_eq;
    logic prio_eq;

    assign created_eq = (i_cand.created == i_best.created);
    assign prio_eq    = (i_cand.prio == i_best.prio);

    // queue priority, then older, then higher job priority, then lower id
    assign o_better = !i_best_vld || (i_cand_qp > i_best_qp) ||
                      ((i_cand_qp == i_best_qp) &&
                       ((i_cand.created < i_best.created) ||
                        (created_eq && ((i_cand.prio > i_best.prio) ||
                                        (prio_eq && (i_cand.id < i_best.id))))));
endmodule

@@ rtl/job_table_priority_scheduler_top.sv @@
// Job table scheduler: a 16-slot job table in one synchronous memory,
// with a command channel, a result channel and a register write port.
//
// Usage: each command transfer on i_cmd yields exactly one result transfer on
// o_res, in order. Registers (queue priorities, queue limits) are written on
// i_cfg_we at any time, and are meant to change only while the block is idle.
// Add, load, seed and unused codes go from the idle state straight to the output
// state, which loads the result register. Lookups, count and reassign read every
// slot through the memory's registered read port, then apply. Pick sweeps the
// memory twice, first to tally active jobs per queue, then to rank candidates.
// One command is in work at a time.
// The result register decouples the sides: a new command is taken while a
// finished result still waits; if the receiver stalls, the next result waits
// in a holding register and the block takes no further command until it moves.
// Reset clears all slot valid bits, sets the id counter to 1 and clears both
// registers; memory contents need no clearing.
module job_table_priority_scheduler_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    jtps_cmd_if.sink                        i_cmd,
    jtps_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [jtps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jtps_pkg::CFG_W-1:0]      i_cfg_data
);
    import jtps_pkg::*;

    t_state                r_state, n_state;
    t_action               r_act;
    logic [31:0]           r_eid, r_now, r_rt;
    logic [2:0]            r_stv;
    logic [3:0]            r_qn;
    logic [SCAN_W-1:0]     r_scan;
    logic                  r_pvld, r_pass;
    logic [IDX_W-1:0]      r_pidx;
    t_entry                r_rdata;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hidx;
    t_entry                r_hent;
    logic                  r_bvld;
    t_entry                r_bent;
    logic signed [7:0]     r_bqp;
    logic [CNT_W-1:0]      r_mcnt;
    logic [ACT_W-1:0]      r_actcnt [NUM_QUEUES];
    logic [31:0]           r_next_id;
    logic [CFG_W-1:0]      r_qprio, r_qlim;
    t_result               r_pend, r_out;
    logic                  r_ovld;

    t_entry                mem [TABLE_DEPTH];

    t_action               in_act;
    logic                  in_fire, needs_scan, scan_done, out_load;
    logic                  free_ok;
    logic [IDX_W-1:0]      free_idx;
    t_result               i_res, a_res;
    logic                  a_wen, a_del;
    t_entry                a_ent, new_ent;
    logic                  w_en;
    logic [IDX_W-1:0]      w_addr;
    t_entry                w_data;
    logic                  e_vld, cand, better, reassign_hit;
    logic [7:0]            lim;
    logic [ACT_W-1:0]      act_n;
    logic signed [7:0]     qp;

    assign in_act     = t_action'(i_cmd.action);
    assign in_fire    = i_cmd.valid && i_cmd.ready;
    assign needs_scan = !(in_act == ACT_ADD || in_act == ACT_LOAD || in_act == ACT_SEED ||
                          i_cmd.action > 4'(ACT_REASSIGN));
    assign scan_done  = (r_scan == SCAN_W'(TABLE_DEPTH)) && !r_pvld;
    assign out_load   = (r_state == S_OUT) && (!r_ovld || o_res.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = needs_scan ? S_SCAN : S_OUT;
            S_SCAN:  if (scan_done && !(r_act == ACT_PICK && !r_pass)) n_state = S_APPLY;
            S_APPLY: n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_cmd.ready       = (r_state == S_IDLE);
        o_res.valid       = r_ovld;
        o_res.result_id   = r_out.result_id;
        o_res.found       = r_out.found;
        o_res.done_flag   = r_out.done_flag;
        o_res.status_out  = r_out.status_out;
        o_res.match_count = r_out.match_count;
    end

    // lowest free slot
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_ok  = 1'b1;
                free_idx = IDX_W'(k);
            end
        end
    end

    // immediate commands
    always_comb begin
        i_res   = '0;
        new_ent = '0;
        new_ent.queue = norm_queue(i_cmd.queue_number);
        if (in_act == ACT_ADD) begin
            new_ent.id      = r_next_id;
            new_ent.status  = ST_QUEUED;
            new_ent.created = i_cmd.now;
            if (free_ok) begin
                i_res.result_id  = r_next_id;
                i_res.found      = 1'b1;
                i_res.status_out = ST_QUEUED;
            end
        end else begin
            new_ent.id      = i_cmd.entry_id;
            new_ent.status  = norm_status(i_cmd.status_value);
            new_ent.prio    = i_cmd.entry_priority;
            new_ent.created = i_cmd.created_time;
            new_ent.retry   = i_cmd.retry_time;
            if (in_act == ACT_LOAD && free_ok) begin
                i_res.result_id  = i_cmd.entry_id;
                i_res.found      = 1'b1;
                i_res.status_out = norm_status(i_cmd.status_value);
            end
        end
    end

    // per-entry scan terms
    always_comb begin
        lim   = '0;
        act_n = '0;
        for (int k = 0; k < NUM_QUEUES; k++) begin
            if (r_rdata.queue == 4'(k + 1)) begin
                lim   = r_qlim[8*k +: 8];
                act_n = r_actcnt[k];
            end
        end
    end

    assign qp    = queue_prio(r_qprio, r_rdata.queue);
    assign e_vld = r_pvld && r_valid[r_pidx];
    assign cand  = e_vld && (r_rdata.status == ST_QUEUED) &&
                   (r_rdata.retry == 32'd0 || r_rdata.retry <= r_now) &&
                   (lim == 8'd0 || 8'(act_n) < lim);
    assign reassign_hit = (r_state == S_SCAN) && (r_act == ACT_REASSIGN) && e_vld &&
                          (r_qn > 4'd1) && (r_rdata.queue == r_qn);

    jtps_rank u_rank (
        .i_cand_qp  (qp),
        .i_cand     (r_rdata),
        .i_best_qp  (r_bqp),
        .i_best     (r_bent),
        .i_best_vld (r_bvld),
        .o_better   (better)
    );

    // modify the addressed entry after the scan
    always_comb begin
        a_res = '0;
        a_wen = 1'b0;
        a_del = 1'b0;
        a_ent = r_hent;
        if (r_act == ACT_PICK) begin
            if (r_bvld) begin
                a_res.result_id  = r_bent.id;
                a_res.found      = 1'b1;
                a_res.status_out = r_bent.status;
            end
        end else if (r_act == ACT_COUNT) begin
            a_res.match_count = r_mcnt;
        end else if (r_act != ACT_REASSIGN && r_hit) begin
            a_res.found      = 1'b1;
            a_res.status_out = r_hent.status;
            unique case (r_act)
                ACT_REMOVE: begin
                    if (r_hent.status == ST_ACTIVE) begin
                        a_ent.cpend = 1'b1;
                        a_wen       = 1'b1;
                    end else begin
                        a_del           = 1'b1;
                        a_res.done_flag = 1'b1;
                    end
                end
                ACT_FORGET: begin
                    if (r_hent.status != ST_ACTIVE) begin
                        a_del           = 1'b1;
                        a_res.done_flag = 1'b1;
                    end
                end
                ACT_CANCEL: begin
                    a_wen = 1'b1;
                    if (r_hent.status == ST_ACTIVE) begin
                        a_ent.cpend     = 1'b1;
                        a_res.done_flag = 1'b1;
                    end else begin
                        a_ent.status = ST_CANCELED;
                    end
                end
                ACT_PAUSE: begin
                    if (r_hent.status == ST_ACTIVE) begin
                        a_ent.ppend     = 1'b1;
                        a_wen           = 1'b1;
                        a_res.done_flag = 1'b1;
                    end else if (r_hent.status == ST_QUEUED) begin
                        a_ent.status = ST_PAUSED;
                        a_wen        = 1'b1;
                    end
                end
                ACT_RESUME: begin
                    if (r_hent.status == ST_PAUSED || r_hent.status == ST_ERROR) begin
                        a_ent.ppend     = 1'b0;
                        a_ent.cpend     = 1'b0;
                        a_ent.retry     = '0;
                        a_ent.status    = ST_QUEUED;
                        a_wen           = 1'b1;
                        a_res.done_flag = 1'b1;
                    end
                end
                ACT_SETSTAT: begin
                    a_ent.status = r_stv;
                    a_wen        = 1'b1;
                end
                ACT_SETRETRY: begin
                    a_ent.retry = r_rt;
                    a_wen       = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // single memory write port
    always_comb begin
        w_en   = 1'b0;
        w_addr = free_idx;
        w_data = new_ent;
        if (r_state == S_IDLE) begin
            w_en = in_fire && free_ok && (in_act == ACT_ADD || in_act == ACT_LOAD);
        end else if (r_state == S_SCAN) begin
            w_en         = reassign_hit;
            w_addr       = r_pidx;
            w_data       = r_rdata;
            w_data.queue = 4'd1;
        end else if (r_state == S_APPLY) begin
            w_en   = a_wen;
            w_addr = r_hidx;
            w_data = a_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) mem[w_addr] <= w_data;
        r_rdata <= mem[r_scan[IDX_W-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_next_id <= 32'd1;
            r_qprio   <= '0;
            r_qlim    <= '0;
            r_ovld    <= 1'b0;
            r_pvld    <= 1'b0;
            r_scan    <= '0;
            r_pass    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_QPRIO) r_qprio <= i_cfg_data;
                if (i_cfg_idx == REG_QLIM)  r_qlim  <= i_cfg_data;
            end
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
            if (r_state == S_IDLE && in_fire) begin
                r_scan <= '0;
                r_pvld <= 1'b0;
                r_pass <= 1'b0;
                if (free_ok && (in_act == ACT_ADD || in_act == ACT_LOAD)) begin
                    r_valid[free_idx] <= 1'b1;
                end
                if (in_act == ACT_ADD && free_ok) begin
                    r_next_id <= r_next_id + 32'd1;
                end else if (in_act == ACT_LOAD && free_ok && i_cmd.entry_id >= r_next_id) begin
                    r_next_id <= i_cmd.entry_id + 32'd1;
                end else if (in_act == ACT_SEED && i_cmd.entry_id > r_next_id) begin
                    r_next_id <= i_cmd.entry_id;
                end
            end else if (r_state == S_SCAN) begin
                if (r_scan != SCAN_W'(TABLE_DEPTH)) begin
                    r_pidx <= r_scan[IDX_W-1:0];
                    r_pvld <= 1'b1;
                    r_scan <= r_scan + SCAN_W'(1);
                end else begin
                    r_pvld <= 1'b0;
                end
                // second sweep of pick: rank candidates
                if (scan_done && r_act == ACT_PICK && !r_pass) begin
                    r_pass <= 1'b1;
                    r_scan <= '0;
                end
            end else if (r_state == S_APPLY && a_del) begin
                r_valid[r_hidx] <= 1'b0;
            end
        end
    end

    // command fields and scan accumulators
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_fire) begin
            r_act  <= in_act;
            r_eid  <= i_cmd.entry_id;
            r_now  <= i_cmd.now;
            r_stv  <= norm_status(i_cmd.status_value);
            r_qn   <= i_cmd.queue_number;
            r_rt   <= i_cmd.retry_time;
            r_hit  <= 1'b0;
            r_bvld <= 1'b0;
            r_mcnt <= '0;
            for (int k = 0; k < NUM_QUEUES; k++) r_actcnt[k] <= '0;
            r_pend <= i_res;
        end else if (r_state == S_SCAN && e_vld) begin
            if (r_act == ACT_COUNT) begin
                if (r_rdata.status == r_stv && r_mcnt != CNT_MAX) r_mcnt <= r_mcnt + CNT_W'(1);
            end else if (r_act == ACT_PICK) begin
                if (!r_pass) begin
                    for (int k = 0; k < NUM_QUEUES; k++) begin
                        if (r_rdata.queue == 4'(k + 1) && r_rdata.status == ST_ACTIVE) begin
                            r_actcnt[k] <= r_actcnt[k] + ACT_W'(1);
                        end
                    end
                end else if (cand && better) begin
                    r_bvld <= 1'b1;
                    r_bent <= r_rdata;
                    r_bqp  <= qp;
                end
            end else if (r_act != ACT_REASSIGN) begin
                // lowest matching slot wins
                if (!r_hit && r_rdata.id == r_eid) begin
                    r_hit  <= 1'b1;
                    r_hidx <= r_pidx;
                    r_hent <= r_rdata;
                end
            end
        end else if (r_state == S_APPLY) begin
            r_pend <= a_res;
        end
        if (out_load) r_out <= r_pend;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.match_count <= CNT_W'(TABLE_DEPTH)))
        else $error("match count exceeds table depth");

    a_done_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (!o_res.done_flag || o_res.found))
        else $error("done flag without a found job");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= SCAN_W'(TABLE_DEPTH))
        else $error("scan index past table depth");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> !$past(in_fire))
        else $error("command taken while a scan runs");
`endif
endmodule
